>>> src/assert_macros.svh
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("check failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("check failed");

`endif

>>> src/fird_pkg.sv
// ----------------------------------------------------------------------------
// fird_pkg
// Constants, types and tap weights of the decimating FIR filter.
// ----------------------------------------------------------------------------
package fird_pkg;
  localparam int Taps        = 161;
  localparam int MaxChannels = 2;
  localparam int SampleBits  = 16;
  localparam int CoefFrac    = 19;
  localparam int CoefBits    = 20;
  localparam int AccBits     = 48;
  localparam int Depth       = Taps * MaxChannels;
  localparam int AddrBits    = $clog2(Depth);
  localparam int PosBits     = $clog2(Taps);
  localparam int ChBits      = 1;

  localparam logic [0:0] CfgFactor = 1'd0;
  localparam logic [0:0] CfgCount  = 1'd1;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [CoefBits-1:0]   coef_t;

  // Half tap set (scaled 1e10); weight = round(b/GAIN*2^19), symmetric.
  localparam longint HalfTaps [81] = '{
    -22979864, -14851155, -5276345, 5287637,
    16288105, 27066298, 36859262, 44820600,
    50064517, 51734225, 49091760, 41622026,
    29140060, 11887658, -9395862, -33443515,
    -58483343, -82321768, -102489292, -116443067,
    -121813339, -116673677, -99809222, -70953669,
    -30964983, 18087642, 72947272, 129315999,
    182126619, 225928091, 255360681, 265684688,
    253317039, 216323992, 154816648, 71199603,
    -29768131, -141127078, -254095608, -358661777,
    -444356705, -501157252, -520448654, -495965416,
    -424622921, -307153754, -148472270, 42291942,
    252127139, 464845605, 662137647, 824916099,
    934864451, 976077458, 936666466, 810194757,
    596811993, 303971839, -53357703, -453047237,
    -866737087, -1261316811, -1600878564, -1849028543,
    -1971406561, -1938239736, -1726744703, -1323195052,
    -724487288, 60931437, 1012868940, 2099971950,
    64'sd3281078087, 64'sd4507269541, 64'sd5724509503, 64'sd6876697384,
    64'sd7908945043, 64'sd8770856432, 64'sd9419588972, 64'sd9822487143,
    64'sd9959106445
  };

  localparam longint Den = 64'd110396931000;

  function automatic longint calc_coef(int k);
    longint b, mag, q;
    b = (k <= 80) ? HalfTaps[k] : HalfTaps[160-k];
    mag = (b < 0) ? -b : b;
    q = (mag * 64'sd524288 + Den / 2) / Den;
    return (b < 0) ? -q : q;
  endfunction

  typedef coef_t coef_arr_t [Taps];

  function automatic coef_arr_t build_coefs();
    coef_arr_t c;
    for (int k = 0; k < Taps; k++) begin
      c[k] = coef_t'(calc_coef(k));
    end
    return c;
  endfunction

  localparam coef_arr_t Coefs = build_coefs();

  // Request handed from the sequencer to the MAC.
  typedef struct packed {
    logic       start;
    logic       pass;
    logic [0:0] ch;
  } mac_ctl_t;
endpackage

>>> src/fird_ram.sv
// ----------------------------------------------------------------------------
// fird_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module fird_ram #(
  parameter int Width = 16,
  parameter int Words = 322
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Words)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Words)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Words];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/fir_decimator_161_tap.sv
// Decimating 161-tap low-pass FIR. Samples are first written into a 322-word
// delay RAM (161 words per channel); after reset or a restart request the RAM
// is swept to zero, one word per cycle, with input stalled. A restart
// request is held stalled during the sweep and is taken after it. Each
// accepted sample that yields a filtered result runs the single shared
// multiply-add over all 161 taps, one tap per cycle through the RAM read
// port, so such a sample keeps the input stalled until its result is
// written; samples without a result, and pass-through samples at factor 1,
// leave the sequencer idle. A finished result sits in an output register;
// while that register is full and stalled, the input is stalled too.
// ----------------------------------------------------------------------------
// fir_decimator_161_tap
// Top level: input sequencer, delay RAM, MAC and output register.
// ----------------------------------------------------------------------------
module fir_decimator_161_tap (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [4:0]                        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [fird_pkg::SampleBits-1:0] in_sample,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [fird_pkg::SampleBits-1:0] out_filtered,
  output logic                              out_channel
);
  import fird_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MAC, S_FIN, S_HOLD} state_t;

  state_t state_r;
  logic [4:0] factor_r;
  logic [1:0] count_r;
  logic [AddrBits-1:0] clr_r;
  logic [PosBits-1:0] wpos_r;
  logic chc_r;
  logic [3:0] phase_r;
  logic [7:0] k_r;
  logic [AddrBits-1:0] base_r;
  logic [PosBits-1:0] rpos_r;
  logic signed [AccBits-1:0] acc_r;
  logic macv_r;
  logic [7:0] mk_r;
  logic ch_r;
  logic pend_r;
  sample_t pend_data_r;
  logic pend_ch_r;
  logic restart_pend_r;

  logic we;
  logic [AddrBits-1:0] waddr, raddr;
  sample_t wdata, rdata;

  fird_ram #(.Width(SampleBits), .Words(Depth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic [4:0] fac;
  logic [1:0] cnt;
  logic       ch_eff, accept, ch_last, fire, pass_load;
  logic [PosBits-1:0] wpos_eff;
  logic [3:0] phase_eff;
  always_comb begin
    fac = (factor_r == 5'd0) ? 5'd1 : ((factor_r > 5'd16) ? 5'd16 : factor_r);
    cnt = (count_r == 2'd0) ? 2'd1 : ((count_r > 2'd2) ? 2'd2 : count_r);
    wpos_eff = wpos_r;
    phase_eff = phase_r;
    ch_eff = (chc_r && cnt == 2'd1) ? 1'b0 : chc_r;
    accept = in_valid && !in_stall;
    ch_last = (cnt == 2'd1) || ch_eff;
    fire = (fac == 5'd1) || (phase_eff == 4'd0);
    pass_load = accept && (fac == 5'd1);
  end

  // Output can take a new result only when the register is free or is being read out.
  // Hold a restart request until the sweep is done.
  assign in_stall = !(state_r == S_IDLE) || (pend_r && out_stall)
                    || (in_valid && in_restart && !restart_pend_r);
  assign out_valid = pend_r;
  assign out_filtered = pend_data_r;
  assign out_channel = pend_ch_r;

  logic [PosBits:0] rsum;
  always_comb begin
    we = 1'b0;
    waddr = clr_r;
    wdata = '0;
    rsum = {1'b0, rpos_r} + 1'b1;
    if (state_r == S_CLEAR) begin
      we = 1'b1;
    end else if (accept) begin
      we = 1'b1;
      waddr = (ch_eff ? AddrBits'(Taps) : '0) + AddrBits'(wpos_eff);
      wdata = in_sample;
    end
    raddr = base_r + AddrBits'(rpos_r);
  end

  // Saturating round of the accumulator.
  logic signed [AccBits-1:0] rnd;
  sample_t sat;
  always_comb begin
    rnd = (acc_r + (AccBits'(1) <<< (CoefFrac-1))) >>> CoefFrac;
    if (rnd > AccBits'(32767)) sat = 16'sd32767;
    else if (rnd < -AccBits'(32768)) sat = -16'sd32768;
    else sat = rnd[SampleBits-1:0];
  end

  logic signed [SampleBits+CoefBits-1:0] prod;
  assign prod = rdata * Coefs[mk_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; factor_r <= 5'd10; count_r <= 2'd1;
      wpos_r <= '0; chc_r <= 1'b0; phase_r <= '0; pend_r <= 1'b0;
      macv_r <= 1'b0; restart_pend_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgFactor) factor_r <= cfg_data;
        else count_r <= cfg_data[1:0];
      end
      if (pend_r && !out_stall && !pass_load) pend_r <= 1'b0;
      macv_r <= (state_r == S_MAC);
      mk_r <= k_r;
      if (macv_r) acc_r <= acc_r + AccBits'(prod);
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= (clr_r == AddrBits'(Depth-1)) ? '0 : clr_r + 1'b1;
          if (clr_r == AddrBits'(Depth-1)) begin
            state_r <= S_IDLE;
            wpos_r <= '0; chc_r <= 1'b0; phase_r <= '0;
          end
        end
        S_IDLE: begin
          if (in_valid && in_restart && !restart_pend_r && !(pend_r && out_stall)) begin
            // Clear first, then take the request afterwards.
            restart_pend_r <= 1'b1;
            state_r <= S_CLEAR;
          end else if (accept) begin
            restart_pend_r <= 1'b0;
            chc_r <= ch_last ? 1'b0 : 1'b1;
            if (ch_last) begin
              wpos_r <= (wpos_eff == PosBits'(Taps-1)) ? '0 : wpos_eff + 1'b1;
              phase_r <= (fac <= 5'd1 || 5'(phase_eff) + 5'd1 >= fac) ? '0
                         : phase_eff + 1'b1;
            end
            if (fac == 5'd1) begin
              pend_r <= 1'b1; pend_data_r <= in_sample; pend_ch_r <= ch_eff;
            end else if (fire) begin
              ch_r <= ch_eff;
              base_r <= ch_eff ? AddrBits'(Taps) : '0;
              rpos_r <= (wpos_eff == PosBits'(Taps-1)) ? '0 : wpos_eff + 1'b1;
              k_r <= '0;
              acc_r <= '0;
              state_r <= S_HOLD;
            end
          end
        end
        S_HOLD: state_r <= S_MAC; // write lands before first read
        S_MAC: begin
          rpos_r <= (rpos_r == PosBits'(Taps-1)) ? '0 : rsum[PosBits-1:0];
          k_r <= k_r + 1'b1;
          if (k_r == 8'(Taps-1)) state_r <= S_FIN;
        end
        S_FIN: begin
          if (!macv_r && !pend_r) begin
            pend_r <= 1'b1; pend_data_r <= sat; pend_ch_r <= ch_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> src/fird_checker.sv
// ----------------------------------------------------------------------------
// fird_checker
// Port-level checks on the decimating FIR filter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module fird_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [15:0] out_filtered
);
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `CHK_NEXT(a_data_hold, clk, rst_n, out_valid && out_stall, $stable(out_filtered))
  `CHK_IMPLY(a_no_take_full, clk, rst_n, out_valid && out_stall, in_stall)
endmodule

bind fir_decimator_161_tap fird_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_filtered(out_filtered)
);
